// File: hw/rtl/sme_pkg.sv
// shared types and codes for the stable matching engine
package sme_pkg;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR,
        ST_B_LEN,
        ST_B_LEN2,
        ST_B_RD,
        ST_B_WR,
        ST_M_POP,
        ST_M_POP2,
        ST_M_NCI,
        ST_M_PREF,
        ST_M_RANK,
        ST_M_EVICT,
        ST_P_RD,
        ST_P_CHK,
        ST_P_WR,
        ST_O_RD,
        ST_O_LD,
        ST_O_SEND
    } state_t;

    // input word kinds, carried on tuser
    localparam logic [1:0] KIND_PROP   = 2'd0;
    localparam logic [1:0] KIND_ACC    = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // register select, paddr bit 2
    localparam logic REG_PCOUNT = 1'b0;
    localparam logic REG_ACOUNT = 1'b1;

    localparam int CFG_W = 7;

endpackage

// File: hw/rtl/stable_matching_engine.sv
// top level of the stable matching engine: loader, sequencer and result stage
//
// usage
//   input channel s_*: one word per item, kind on s_tuser. preference entries
//   write one ram place each; a run word starts gale-shapley matching on the
//   stored lists with proposer_count and acceptor_count (apb, 0x0 and 0x4).
//   output channel m_*: one word per proposer in use, in index order, with
//   m_tlast on the last one.
// run sequence
//   s_tready stays high through load words.
//   a run clears the rank table (next choice
//   and best rank stores and the queue are set in the same pass), then reads
//   each acceptor list to build ranks, handles proposals (with an eviction,
//   to an unused acceptor or for an exhausted proposer), collects partners
//   per acceptor and sends the result words, holding on receiver stalls.
//   s_tready is low from the run word until the last result is taken.
// reset
//   lengths read as zero, counts are 64, queue empty; lists undefined until loaded.
// stall
//   a result word holds in the output register until m_tready; the sequencer waits.
module stable_matching_engine
    import sme_pkg::*;
#(
    parameter int MAX_PEOPLE = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // input word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // person[5:0], position[11:6], choice[17:12],
                                   // list_length[24:18], zero fill
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // result word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // proposer[5:0], partner[11:6], matched[12],
                                   // zero fill
    output logic        m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N    = MAX_PEOPLE;
    localparam int AW   = $clog2(N);
    localparam int CW   = $clog2(N + 1);
    localparam int FLAT = N * N;
    localparam int FW   = $clog2(FLAT);
    localparam int CLRW = $clog2(FLAT + 1);

    // flat row-major address into the square stores
    function automatic logic [FW-1:0] flat(input logic [AW-1:0] row, input logic [AW-1:0] col);
        flat = FW'(row) * FW'(N) + FW'(col);
    endfunction

    function automatic logic [CW-1:0] clamp_len(input logic [CFG_W-1:0] v);
        clamp_len = (v > CFG_W'(N)) ? CW'(N) : v[CW-1:0];
    endfunction

    // input word fields
    logic [5:0] in_person, in_position, in_choice;
    logic [6:0] in_len;
    assign in_person   = s_tdata[5:0];
    assign in_position = s_tdata[11:6];
    assign in_choice   = s_tdata[17:12];
    assign in_len      = s_tdata[24:18];

    // registers
    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    pcount_reg, acount_reg;
    logic [CLRW-1:0]     c_reg, c_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [AW-1:0]       p_reg, p_next;
    logic [AW-1:0]       sel_reg, sel_next;
    logic [AW-1:0]       qhead_reg, qhead_next;
    logic [CW-1:0]       qcount_reg, qcount_next;
    logic [N-1:0]        lvp_reg, lvp_next;      // proposer length written
    logic [N-1:0]        lva_reg, lva_next;      // acceptor length written
    logic [N-1:0]        hvld_reg, hvld_next;    // proposer has partner
    logic                mvalid_reg, mvalid_next;
    logic [5:0]          mprop_reg, mprop_next;
    logic [5:0]          mpart_reg, mpart_next;
    logic                mmatch_reg, mmatch_next;
    logic                mlast_reg, mlast_next;

    // ram ports
    logic          pp_we;   logic [FW-1:0] pp_waddr, pp_raddr; logic [5:0] pp_wdata, pp_rdata;
    logic          ap_we;   logic [FW-1:0] ap_waddr, ap_raddr; logic [5:0] ap_wdata, ap_rdata;
    logic          rk_we;   logic [FW-1:0] rk_waddr, rk_raddr; logic [CW-1:0] rk_wdata, rk_rdata;
    logic          pl_we;   logic [AW-1:0] pl_waddr, pl_raddr; logic [CW-1:0] pl_wdata, pl_rdata;
    logic          al_we;   logic [AW-1:0] al_waddr, al_raddr; logic [CW-1:0] al_wdata, al_rdata;
    logic          nc_we;   logic [AW-1:0] nc_waddr, nc_raddr; logic [CW-1:0] nc_wdata, nc_rdata;
    logic          bs_we;   logic [AW-1:0] bs_waddr, bs_raddr; logic [CW-1:0] bs_wdata, bs_rdata;
    logic          q_we;    logic [AW-1:0] q_waddr, q_raddr;   logic [AW-1:0] q_wdata, q_rdata;
    logic          pt_we;   logic [AW-1:0] pt_waddr, pt_raddr; logic [AW-1:0] pt_wdata, pt_rdata;

    sme_ram #(.WIDTH(6), .DEPTH(FLAT)) u_pprefs (.clk(clk), .we(pp_we), .waddr(pp_waddr),
        .wdata(pp_wdata), .raddr(pp_raddr), .rdata(pp_rdata));
    sme_ram #(.WIDTH(6), .DEPTH(FLAT)) u_aprefs (.clk(clk), .we(ap_we), .waddr(ap_waddr),
        .wdata(ap_wdata), .raddr(ap_raddr), .rdata(ap_rdata));
    sme_ram #(.WIDTH(CW), .DEPTH(FLAT)) u_rank (.clk(clk), .we(rk_we), .waddr(rk_waddr),
        .wdata(rk_wdata), .raddr(rk_raddr), .rdata(rk_rdata));
    sme_ram #(.WIDTH(CW), .DEPTH(N)) u_plen (.clk(clk), .we(pl_we), .waddr(pl_waddr),
        .wdata(pl_wdata), .raddr(pl_raddr), .rdata(pl_rdata));
    sme_ram #(.WIDTH(CW), .DEPTH(N)) u_alen (.clk(clk), .we(al_we), .waddr(al_waddr),
        .wdata(al_wdata), .raddr(al_raddr), .rdata(al_rdata));
    sme_ram #(.WIDTH(CW), .DEPTH(N)) u_nci (.clk(clk), .we(nc_we), .waddr(nc_waddr),
        .wdata(nc_wdata), .raddr(nc_raddr), .rdata(nc_rdata));
    sme_ram #(.WIDTH(CW), .DEPTH(N)) u_best (.clk(clk), .we(bs_we), .waddr(bs_waddr),
        .wdata(bs_wdata), .raddr(bs_raddr), .rdata(bs_rdata));
    sme_ram #(.WIDTH(AW), .DEPTH(N)) u_queue (.clk(clk), .we(q_we), .waddr(q_waddr),
        .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata));
    sme_ram #(.WIDTH(AW), .DEPTH(N)) u_partner (.clk(clk), .we(pt_we), .waddr(pt_waddr),
        .wdata(pt_wdata), .raddr(pt_raddr), .rdata(pt_rdata));

    // effective counts, zero reads as one and large values saturate
    logic [CW-1:0] np, na;
    assign np = (pcount_reg == '0) ? CW'(1) : clamp_len(pcount_reg);
    assign na = (acount_reg == '0) ? CW'(1) : clamp_len(acount_reg);

    // shared conditions for both control blocks
    logic          s_acc, load_ok, is_run;
    logic          clr_done, b_j_done, b_k_done, q_empty;
    logic [CW-1:0] nci_val, plen_val, best_val, pbest_val;
    logic          exhausted, acc_bad, better;
    logic [CW-1:0] q_sum;
    logic [AW-1:0] q_tail;
    logic          q_room;

    assign s_acc     = s_tvalid && s_tready;
    assign is_run    = (s_tuser == KIND_RUN);
    assign load_ok   = (s_tuser == KIND_PROP || s_tuser == KIND_ACC)
                       && (7'(in_person) < 7'(N)) && (7'(in_position) < 7'(N));
    assign clr_done  = (c_reg == CLRW'(FLAT - 1));
    assign b_j_done  = (j_reg >= na);
    assign b_k_done  = (k_reg >= len_reg);
    assign q_empty   = (qcount_reg == '0);
    assign nci_val   = nc_rdata;
    assign plen_val  = lvp_reg[p_reg] ? pl_rdata : '0;
    assign exhausted = (nci_val >= plen_val);
    assign acc_bad   = (7'(pp_rdata) >= 7'(na));
    assign best_val  = bs_rdata;
    assign better    = (rk_rdata > best_val);
    assign pbest_val = bs_rdata;
    assign q_sum     = CW'(qhead_reg) + qcount_reg;
    assign q_tail    = (q_sum >= CW'(N)) ? AW'(q_sum - CW'(N)) : q_sum[AW-1:0];
    assign q_room    = (qcount_reg < CW'(N));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_acc && is_run) state_next = ST_CLR;
            ST_CLR:     if (clr_done) state_next = ST_B_LEN;
            ST_B_LEN:   state_next = b_j_done ? ST_M_POP : ST_B_LEN2;
            ST_B_LEN2:  state_next = ST_B_RD;
            ST_B_RD:    state_next = b_k_done ? ST_B_LEN : ST_B_WR;
            ST_B_WR:    state_next = ST_B_RD;
            ST_M_POP:   state_next = q_empty ? ST_P_RD : ST_M_POP2;
            ST_M_POP2:  state_next = ST_M_NCI;
            ST_M_NCI:   state_next = exhausted ? ST_M_POP : ST_M_PREF;
            ST_M_PREF:  state_next = acc_bad ? ST_M_POP : ST_M_RANK;
            ST_M_RANK:  state_next = (better && best_val != '0) ? ST_M_EVICT : ST_M_POP;
            ST_M_EVICT: state_next = ST_M_POP;
            ST_P_RD:    state_next = b_j_done ? ST_O_RD : ST_P_CHK;
            ST_P_CHK:   state_next = (pbest_val != '0) ? ST_P_WR : ST_P_RD;
            ST_P_WR:    state_next = ST_P_RD;
            ST_O_RD:    state_next = ST_O_LD;
            ST_O_LD:    state_next = ST_O_SEND;
            ST_O_SEND:  if (m_tready) state_next = mlast_reg ? ST_IDLE : ST_O_RD;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        c_next = c_reg;           j_next = j_reg;          k_next = k_reg;
        len_next = len_reg;       p_next = p_reg;          sel_next = sel_reg;
        qhead_next = qhead_reg;   qcount_next = qcount_reg;
        lvp_next = lvp_reg;       lva_next = lva_reg;      hvld_next = hvld_reg;
        mvalid_next = mvalid_reg; mprop_next = mprop_reg;  mpart_next = mpart_reg;
        mmatch_next = mmatch_reg; mlast_next = mlast_reg;

        pp_we = 1'b0; pp_waddr = flat(in_person[AW-1:0], in_position[AW-1:0]);
        pp_wdata = in_choice; pp_raddr = '0;
        ap_we = 1'b0; ap_waddr = flat(in_person[AW-1:0], in_position[AW-1:0]);
        ap_wdata = in_choice; ap_raddr = '0;
        rk_we = 1'b0; rk_waddr = c_reg[FW-1:0]; rk_wdata = '0; rk_raddr = '0;
        pl_we = 1'b0; pl_waddr = in_person[AW-1:0]; pl_wdata = clamp_len(in_len);
        pl_raddr = '0;
        al_we = 1'b0; al_waddr = in_person[AW-1:0]; al_wdata = clamp_len(in_len);
        al_raddr = '0;
        nc_we = 1'b0; nc_waddr = p_reg; nc_wdata = nci_val + CW'(1); nc_raddr = '0;
        bs_we = 1'b0; bs_waddr = sel_reg; bs_wdata = rk_rdata; bs_raddr = '0;
        q_we = 1'b0; q_waddr = q_tail; q_wdata = p_reg; q_raddr = qhead_reg;
        pt_we = 1'b0; pt_waddr = ap_rdata[AW-1:0]; pt_wdata = j_reg[AW-1:0];
        pt_raddr = j_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && is_run)
                begin
                    c_next    = '0;
                    hvld_next = '0;
                end
                else if (s_acc && load_ok)
                begin
                    if (s_tuser == KIND_PROP)
                    begin
                        pp_we = 1'b1;
                        pl_we = 1'b1;
                        lvp_next[in_person[AW-1:0]] = 1'b1;
                    end
                    else
                    begin
                        ap_we = 1'b1;
                        al_we = 1'b1;
                        lva_next[in_person[AW-1:0]] = 1'b1;
                    end
                end
            end
            ST_CLR:
            begin
                // clear rank table, next choice and best rank stores,
                // seed the queue with every proposer in use
                rk_we = 1'b1;
                if (c_reg < CLRW'(N))
                begin
                    nc_we    = 1'b1;
                    nc_waddr = c_reg[AW-1:0];
                    nc_wdata = '0;
                    bs_we    = 1'b1;
                    bs_waddr = c_reg[AW-1:0];
                    bs_wdata = '0;
                end
                if (c_reg < CLRW'(np))
                begin
                    q_we    = 1'b1;
                    q_waddr = c_reg[AW-1:0];
                    q_wdata = c_reg[AW-1:0];
                end
                c_next = c_reg + CLRW'(1);
                if (clr_done)
                begin
                    j_next      = '0;
                    qhead_next  = '0;
                    qcount_next = np;
                end
            end
            ST_B_LEN:
            begin
                al_raddr = j_reg[AW-1:0];
            end
            ST_B_LEN2:
            begin
                len_next = lva_reg[j_reg[AW-1:0]] ? al_rdata : '0;
                k_next   = '0;
            end
            ST_B_RD:
            begin
                ap_raddr = flat(j_reg[AW-1:0], k_reg[AW-1:0]);
                if (b_k_done)
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            ST_B_WR:
            begin
                // later list places overwrite earlier ones
                if (7'(ap_rdata) < 7'(np))
                begin
                    rk_we    = 1'b1;
                    rk_waddr = flat(j_reg[AW-1:0], ap_rdata[AW-1:0]);
                    rk_wdata = CW'(N) - k_reg;
                end
                k_next = k_reg + CW'(1);
            end
            ST_M_POP:
            begin
                if (!q_empty)
                begin
                    qhead_next  = (qhead_reg == AW'(N - 1)) ? '0 : qhead_reg + AW'(1);
                    qcount_next = qcount_reg - CW'(1);
                end
                else
                begin
                    j_next = '0;
                end
            end
            ST_M_POP2:
            begin
                p_next   = q_rdata;
                nc_raddr = q_rdata;
                pl_raddr = q_rdata;
            end
            ST_M_NCI:
            begin
                pp_raddr = flat(p_reg, nci_val[AW-1:0]);
                if (!exhausted)
                begin
                    nc_we = 1'b1;
                end
            end
            ST_M_PREF:
            begin
                sel_next = pp_rdata[AW-1:0];
                rk_raddr = flat(pp_rdata[AW-1:0], p_reg);
                bs_raddr = pp_rdata[AW-1:0];
                if (acc_bad && q_room)
                begin
                    q_we        = 1'b1;
                    qcount_next = qcount_reg + CW'(1);
                end
            end
            ST_M_RANK:
            begin
                ap_raddr = flat(sel_reg, AW'(CW'(N) - best_val));
                if (better)
                begin
                    bs_we = 1'b1;
                end
                else if (q_room)
                begin
                    q_we        = 1'b1;
                    qcount_next = qcount_reg + CW'(1);
                end
            end
            ST_M_EVICT:
            begin
                // the displaced proposer goes back to the queue
                if (q_room)
                begin
                    q_we        = 1'b1;
                    q_wdata     = ap_rdata[AW-1:0];
                    qcount_next = qcount_reg + CW'(1);
                end
            end
            ST_P_RD:
            begin
                bs_raddr = j_reg[AW-1:0];
                if (b_j_done)
                begin
                    j_next = '0;
                end
            end
            ST_P_CHK:
            begin
                ap_raddr = flat(j_reg[AW-1:0], AW'(CW'(N) - pbest_val));
                if (pbest_val == '0)
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            ST_P_WR:
            begin
                if (7'(ap_rdata) < 7'(N))
                begin
                    pt_we = 1'b1;
                    hvld_next[ap_rdata[AW-1:0]] = 1'b1;
                end
                j_next = j_reg + CW'(1);
            end
            ST_O_RD:
            begin
                pt_raddr = j_reg[AW-1:0];
            end
            ST_O_LD:
            begin
                mvalid_next = 1'b1;
                mprop_next  = 6'(j_reg);
                mmatch_next = hvld_reg[j_reg[AW-1:0]];
                mpart_next  = hvld_reg[j_reg[AW-1:0]] ? 6'(pt_rdata) : 6'd0;
                mlast_next  = ((j_reg + CW'(1)) == np);
            end
            ST_O_SEND:
            begin
                if (m_tready)
                begin
                    mvalid_next = 1'b0;
                    j_next      = j_reg + CW'(1);
                end
            end
            default:
            begin
                c_next = c_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            qhead_reg  <= '0;
            qcount_reg <= '0;
            lvp_reg    <= '0;
            lva_reg    <= '0;
            hvld_reg   <= '0;
            mvalid_reg <= 1'b0;
            c_reg      <= '0;
            j_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            qhead_reg  <= qhead_next;
            qcount_reg <= qcount_next;
            lvp_reg    <= lvp_next;
            lva_reg    <= lva_next;
            hvld_reg   <= hvld_next;
            mvalid_reg <= mvalid_next;
            c_reg      <= c_next;
            j_reg      <= j_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        len_reg    <= len_next;
        p_reg      <= p_next;
        sel_reg    <= sel_next;
        mprop_reg  <= mprop_next;
        mpart_reg  <= mpart_next;
        mmatch_reg <= mmatch_next;
        mlast_reg  <= mlast_next;
    end

    // register port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= CFG_W'(64);
            acount_reg <= CFG_W'(64);
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_ACOUNT)
            begin
                acount_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                pcount_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PCOUNT) ? {25'd0, pcount_reg} : {25'd0, acount_reg};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {3'd0, mmatch_reg, mpart_reg, mprop_reg};
    assign m_tlast  = mlast_reg;

endmodule

// File: hw/rtl/sme_ram.sv
// generic single write port ram with registered read
module sme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/sme_checker.sv
// port-level checks of the stable matching engine and their bind
module sme_checker
    import sme_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // the input is closed after a run word is taken
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == KIND_RUN) |=> !s_tready)
        else $error("input open after run word");

    // load words never stall the input
    a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser != KIND_RUN) |=> s_tready)
        else $error("input closed after load word");

    // input and output are never open together
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("result pending while input open");

    // the last result reopens the input
    a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("input not reopened after last result");

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result word changed");

endmodule

bind stable_matching_engine sme_checker u_sme_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/sv/tb_stable_matching_engine.sv
// testbench for the stable matching engine: random lists, runs and a matching predictor
module tb_stable_matching_engine;
    import sme_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PEOPLE = 64;

    // one result word as the predictor sees it
    typedef struct packed {
        logic [5:0] proposer;
        logic [5:0] partner;
        logic       matched;
        logic       last;
    } match_t;

    // predictor and store of expected pairings
    class match_board;
        logic [5:0] prop_pref [PEOPLE][PEOPLE];
        logic [6:0] prop_len  [PEOPLE];
        logic [5:0] acc_pref  [PEOPLE][PEOPLE];
        logic [6:0] acc_len   [PEOPLE];
        logic [6:0] prop_count = 7'd64;
        logic [6:0] acc_count  = 7'd64;
        match_t     pairings [$];
        int         errors = 0;

        function new();
            foreach (prop_len[i])
            begin
                prop_len[i] = '0;
                acc_len[i]  = '0;
            end
        endfunction

        function void set_count(logic sel, logic [31:0] value);
            if (sel == REG_PCOUNT)
                prop_count = value[6:0];
            else
                acc_count = value[6:0];
        endfunction

        function int clamp(logic [6:0] v);
            if (v == 0)
                return 1;
            return (v > PEOPLE) ? PEOPLE : int'(v);
        endfunction

        // gale-shapley from a fifo of free proposers, proposer-optimal
        function void run_match();
            int         np;
            int         na;
            logic [6:0] rank [PEOPLE][PEOPLE];
            logic [6:0] held [PEOPLE];
            int         nxt  [PEOPLE];
            bit         has  [PEOPLE];
            logic [5:0] mate [PEOPLE];
            int         free_q [$];
            int         i;
            int         j;
            int         p;
            int         len;
            match_t     e;
            np = clamp(prop_count);
            na = clamp(acc_count);
            foreach (rank[a, b])
                rank[a][b] = '0;
            foreach (held[a])
            begin
                held[a] = '0;
                nxt[a]  = 0;
                has[a]  = 0;
                mate[a] = '0;
            end
            // later places overwrite earlier ones, unused proposers skipped
            for (j = 0; j < na; j++)
            begin
                len = (acc_len[j] > PEOPLE) ? PEOPLE : int'(acc_len[j]);
                for (int k = 0; k < len; k++)
                begin
                    p = acc_pref[j][k];
                    if (p < np)
                        rank[j][p] = 7'(PEOPLE - k);
                end
            end
            for (i = 0; i < np; i++)
                free_q = {free_q, i};
            while (free_q.size() > 0)
            begin
                i = free_q.pop_front();
                len = (prop_len[i] > PEOPLE) ? PEOPLE : int'(prop_len[i]);
                if (nxt[i] >= len)
                    continue;          // list exhausted, stays single
                j = prop_pref[i][nxt[i]];
                nxt[i]++;
                if (j >= na)
                    free_q = {free_q, i};
                else if (rank[j][i] > held[j])
                begin
                    if (held[j] != 0)
                        free_q = {free_q, int'(acc_pref[j][PEOPLE - held[j]])};
                    held[j] = rank[j][i];
                end
                else
                    free_q = {free_q, i};
            end
            for (j = 0; j < na; j++)
                if (held[j] != 0)
                begin
                    p = acc_pref[j][PEOPLE - held[j]];
                    mate[p] = 6'(j);
                    has[p]  = 1;
                end
            for (i = 0; i < np; i++)
            begin
                e.proposer = 6'(i);
                e.partner  = has[i] ? mate[i] : 6'd0;
                e.matched  = has[i];
                e.last     = (i + 1 == np);
                pairings = {pairings, e};
            end
        endfunction

        function void note_word(logic [1:0] kind, logic [5:0] person, logic [5:0] position,
                                logic [5:0] choice, logic [6:0] list_length);
            logic [6:0] len;
            len = (list_length > PEOPLE) ? 7'(PEOPLE) : list_length;
            case (kind)
                KIND_PROP:
                begin
                    prop_pref[person][position] = choice;
                    prop_len[person] = len;
                end
                KIND_ACC:
                begin
                    acc_pref[person][position] = choice;
                    acc_len[person] = len;
                end
                KIND_RUN: run_match();
                default: ;
            endcase
        endfunction

        function void check_result(match_t got);
            match_t want;
            if (pairings.size() == 0)
            begin
                $error("result word with nothing expected: proposer %0d", got.proposer);
                errors++;
                return;
            end
            want = pairings.pop_front();
            if (got.proposer !== want.proposer)
            begin
                $error("proposer: expected %0d, actual %0d", want.proposer, got.proposer);
                errors++;
            end
            if (got.partner !== want.partner)
            begin
                $error("partner: expected %0d, actual %0d", want.partner, got.partner);
                errors++;
            end
            if (got.matched !== want.matched)
            begin
                $error("matched: expected %0d, actual %0d", want.matched, got.matched);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    match_board board = new();
    bit         quiet = 0;      // no idling on either side while set
    int         sink_hold = 0;
    int         loads = 0;

    // which list places were ever written, so a run never reads an empty one
    bit         prop_done [PEOPLE][PEOPLE];
    bit         acc_done  [PEOPLE][PEOPLE];

    stable_matching_engine #(.MAX_PEOPLE(PEOPLE)) DUT (.*);

    always #5 clk = ~clk;

    // hard stop well beyond the slowest legal run
    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int gap_len();
        if (quiet || $urandom_range(0, 9) < 6)
            return 0;
        return ($urandom_range(0, 4) < 4) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // result side: check accepted words, stall at random
    always @(posedge clk)
    begin
        logic ready_next;
        if (rst_n && m_tvalid && m_tready)
            board.check_result({m_tdata[5:0], m_tdata[11:6], m_tdata[12], m_tlast});
        if (sink_hold > 0)
        begin
            sink_hold--;
            ready_next = 0;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            sink_hold = gap_len();
            ready_next = 0;
        end
        else
            ready_next = 1;
        m_tready <= ready_next;
    end

    // send one word and wait for it to be taken; valid stays up for a following word
    task automatic send_word(logic [1:0] kind, logic [5:0] person, logic [5:0] position,
                             logic [5:0] choice, logic [6:0] list_length);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, list_length, choice, position, person};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_word(kind, person, position, choice, list_length);
        if (kind != KIND_RUN)
            loads++;
    endtask

    // input goes quiet before waiting or register writes
    task automatic idle_input();
        s_tvalid <= 0;
    endtask

    task automatic write_count(logic sel, logic [31:0] value);
        idle_input();
        @(posedge clk);
        psel    <= 1;
        pwrite  <= 1;
        penable <= 0;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.set_count(sel, value);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    // whole list, places in order, same length on every entry
    task automatic load_list(logic [1:0] kind, int person, int list_length, int choice_max);
        int n;
        n = (list_length > PEOPLE) ? PEOPLE : list_length;
        for (int k = 0; k < n; k++)
        begin
            send_word(kind, 6'(person), 6'(k), 6'($urandom_range(0, choice_max)),
                      7'(list_length));
            if (kind == KIND_PROP)
                prop_done[person][k] = 1;
            else
                acc_done[person][k] = 1;
        end
    endtask

    // single entry anywhere; the length never reaches an unwritten place
    task automatic stray_entry(logic [1:0] kind, int person);
        int pos;
        int prefix;
        pos = $urandom_range(0, PEOPLE - 1);
        if (kind == KIND_PROP)
            prop_done[person][pos] = 1;
        else
            acc_done[person][pos] = 1;
        prefix = 0;
        while (prefix < PEOPLE &&
               ((kind == KIND_PROP) ? prop_done[person][prefix] : acc_done[person][prefix]))
            prefix++;
        send_word(kind, 6'(person), 6'(pos), 6'($urandom),
                  7'((prefix == PEOPLE) ? $urandom_range(64, 127) : $urandom_range(0, prefix)));
    endtask

    // registers only change once every result is out and the run has settled
    task automatic drain();
        idle_input();
        while (board.pairings.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        int np;
        int na;
        int rounds;
        int lists;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // directed: unused kind, all-ones fields, extreme person and place
        send_word(KIND_UNUSED, 6'd63, 6'd63, 6'd63, 7'd127);
        stray_entry(KIND_PROP, 63);
        stray_entry(KIND_ACC, 63);

        // three proposers, two acceptors: proposals to an unused acceptor,
        // acceptor lists naming unused proposers, repeated entries, eviction
        write_count(REG_PCOUNT, 3);
        write_count(REG_ACOUNT, 2);
        send_word(KIND_PROP, 0, 0, 0, 2);
        send_word(KIND_PROP, 0, 1, 1, 2);
        send_word(KIND_PROP, 1, 0, 0, 1);
        send_word(KIND_PROP, 2, 0, 2, 2);
        send_word(KIND_PROP, 2, 1, 0, 2);
        send_word(KIND_ACC, 0, 0, 1, 4);
        send_word(KIND_ACC, 0, 1, 5, 4);
        send_word(KIND_ACC, 0, 2, 2, 4);
        send_word(KIND_ACC, 0, 3, 1, 4);
        send_word(KIND_ACC, 1, 0, 0, 1);
        for (int k = 0; k < 2; k++)
        begin
            prop_done[0][k] = 1;
            prop_done[2][k] = 1;
        end
        prop_done[1][0] = 1;
        for (int k = 0; k < 4; k++)
            acc_done[0][k] = 1;
        acc_done[1][0] = 1;
        send_word(KIND_RUN, 0, 0, 0, 0);
        drain();

        // counts of zero and above range clamp
        write_count(REG_PCOUNT, 0);
        write_count(REG_ACOUNT, 127);
        send_word(KIND_RUN, 63, 63, 63, 0);
        drain();
        write_count(REG_PCOUNT, 64);
        write_count(REG_ACOUNT, 64);
        send_word(KIND_RUN, 0, 0, 0, 0);
        drain();

        // random rounds: set counts, load lists, run
        rounds = 0;
        while (loads < 150 || rounds < 6)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            np = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 127) : $urandom_range(1, 8);
            na = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 127) : $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0)
                np = 0;
            write_count(REG_PCOUNT, np);
            write_count(REG_ACOUNT, na);
            np = (np == 0) ? 1 : ((np > PEOPLE) ? PEOPLE : np);
            na = (na == 0) ? 1 : ((na > PEOPLE) ? PEOPLE : na);
            lists = $urandom_range(3, 8);
            for (int l = 0; l < lists; l++)
            begin
                logic [1:0] kind;
                int         who;
                int         used;
                int         len;
                kind = $urandom_range(0, 1) ? KIND_ACC : KIND_PROP;
                used = (kind == KIND_PROP) ? np : na;
                who  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, PEOPLE - 1)
                                                   : $urandom_range(0, used - 1);
                if ($urandom_range(0, 40) == 0)
                    len = $urandom_range(64, 127);
                else
                    len = $urandom_range(0, 7);
                load_list(kind, who, len,
                          (kind == KIND_PROP) ? ((na + 1 > 63) ? 63 : na + 1)
                                              : ((np + 1 > 63) ? 63 : np + 1));
                if ($urandom_range(0, 5) == 0)
                    stray_entry(kind, who);
                if ($urandom_range(0, 9) == 0)
                    send_word(KIND_UNUSED, 6'($urandom), 6'($urandom), 6'($urandom),
                              7'($urandom));
            end
            send_word(KIND_RUN, 6'($urandom), 6'($urandom), 6'($urandom), 7'($urandom));
            drain();
            rounds++;
        end

        repeat (50) @(posedge clk);
        if (board.errors == 0 && board.pairings.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
